>>> design/rcsb_pkg.sv
// ----------------------------------------------------------------------------
// rcsb_pkg
// shared widths, operation codes and controller/datapath signal groups
// ----------------------------------------------------------------------------
package rcsb_pkg;

  localparam int OP_W     = 2;
  localparam int POS_W    = 10;
  localparam int LETTER_W = 5;
  localparam int LEN_W    = 11;

  localparam int MAX_LEN_DEFAULT  = 1024;
  localparam int ALPHABET_DEFAULT = 26;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_SORT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic load;
    logic read;
    logic sort_start;
    logic count_issue;
    logic fill_start;
    logic fill_step;
  } cmd_t;

  typedef struct packed {
    logic sort_ok;
    logic ptr_last;
    logic bin_empty;
  } sts_t;

endpackage

>>> design/rcsb_datapath.sv
// ----------------------------------------------------------------------------
// rcsb_datapath
// letter store, histogram bins, range pointer and length register
// ----------------------------------------------------------------------------
module rcsb_datapath
  import rcsb_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEFAULT,
  parameter int ALPHABET = ALPHABET_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [POS_W-1:0]    position,
  input  logic [LETTER_W-1:0] letter,
  input  logic [POS_W-1:0]    range_start,
  input  logic [POS_W-1:0]    range_end,
  input  logic                ascending,
  input  logic                cfg_we,
  input  logic [LEN_W-1:0]    cfg_wdata,
  output logic [LETTER_W-1:0] read_letter,
  output logic                out_of_range
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int BW    = $clog2(ALPHABET);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int WW    = ((LEN_W > AW) ? LEN_W : AW) + 1;

  localparam logic [WW-1:0]       MAX_LEN_W = WW'(MAX_LEN);
  localparam logic [LETTER_W:0]   ALPHA_EXT = (LETTER_W + 1)'(ALPHABET);
  localparam logic [LETTER_W-1:0] TOP_CODE  = LETTER_W'(ALPHABET - 1);
  localparam logic [BW-1:0]       TOP_BIN   = BW'(ALPHABET - 1);

  logic [LEN_W-1:0]    text_length;
  logic [LETTER_W-1:0] mem [MAX_LEN];
  logic [LETTER_W-1:0] rdata;
  logic [CNT_W-1:0]    hist [ALPHABET];
  logic [AW-1:0]       lo;
  logic [AW-1:0]       hi;
  logic [AW-1:0]       ptr;
  logic [BW-1:0]       bin;
  logic                up;
  logic                cnt_valid;
  logic                oor;

  logic [WW-1:0]       len_eff;
  logic                pos_ok;
  logic [LETTER_W-1:0] load_code;
  logic [LETTER_W-1:0] cnt_code;
  logic [BW-1:0]       hidx;
  logic [CNT_W-1:0]    hist_rd;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [LETTER_W-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;

  always_comb begin
    len_eff   = (WW'(text_length) > MAX_LEN_W) ? MAX_LEN_W : WW'(text_length);
    pos_ok    = WW'(position) < len_eff;
    load_code = ({1'b0, letter} >= ALPHA_EXT) ? TOP_CODE : letter;
    cnt_code  = ({1'b0, rdata} >= ALPHA_EXT) ? TOP_CODE : rdata;
    hidx      = cnt_valid ? cnt_code[BW-1:0] : bin;
    hist_rd   = hist[hidx];

    sts.sort_ok   = (range_start <= range_end) && (WW'(range_end) < len_eff);
    sts.ptr_last  = ptr == hi;
    sts.bin_empty = hist_rd == '0;

    mem_we    = (cmd.load && pos_ok) || (cmd.fill_step && !sts.bin_empty);
    mem_waddr = cmd.load ? AW'(position) : ptr;
    mem_wdata = cmd.load ? load_code : LETTER_W'(bin);
    mem_re    = cmd.read || cmd.count_issue;
    mem_raddr = cmd.read ? AW'(position) : ptr;

    read_letter  = oor ? '0 : rdata;
    out_of_range = oor;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= LEN_RESET;
      cnt_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_length <= cfg_wdata;
      end
      cnt_valid <= cmd.count_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sort_start) begin
      for (int i = 0; i < ALPHABET; i++) begin
        hist[i] <= '0;
      end
    end else if (cnt_valid) begin
      hist[hidx] <= hist_rd + 1'b1;
    end else if (cmd.fill_step && !sts.bin_empty) begin
      hist[hidx] <= hist_rd - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      oor <= !pos_ok;
    end
    if (cmd.sort_start) begin
      lo  <= AW'(range_start);
      hi  <= AW'(range_end);
      ptr <= AW'(range_start);
      up  <= ascending;
    end else if (cmd.count_issue) begin
      ptr <= ptr + 1'b1;
    end else if (cmd.fill_start) begin
      ptr <= lo;
      bin <= up ? '0 : TOP_BIN;
    end else if (cmd.fill_step) begin
      if (sts.bin_empty) begin
        bin <= up ? bin + 1'b1 : bin - 1'b1;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

endmodule

>>> design/rcsb_ctrl.sv
// ----------------------------------------------------------------------------
// rcsb_ctrl
// request decode and sequencing of the count and rewrite passes
// ----------------------------------------------------------------------------
module rcsb_ctrl
  import rcsb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] op,
  input  sts_t            sts,
  output cmd_t            cmd,
  output logic            busy,
  output logic            result_strobe
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  always_comb begin
    accept        = start && (state == S_IDLE);
    busy          = state != S_IDLE;
    result_strobe = state == S_READ;

    cmd.load        = accept && (op == OP_LOAD);
    cmd.read        = accept && (op == OP_READ);
    cmd.sort_start  = accept && (op == OP_SORT) && sts.sort_ok;
    cmd.count_issue = state == S_COUNT;
    cmd.fill_start  = state == S_DRAIN;
    cmd.fill_step   = state == S_FILL;

    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.read) begin
          state_next = S_READ;
        end else if (cmd.sort_start) begin
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        if (sts.ptr_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FILL;
      end
      S_FILL: begin
        if (!sts.bin_empty && sts.ptr_last) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> result_strobe)
    else $error("read request without result");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(cmd.read))
    else $error("result without read request");

  a_sort_holds_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.sort_start |=> busy && !result_strobe)
    else $error("sort request did not start a pass");

  a_drain_after_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.count_issue && sts.ptr_last) |=> cmd.fill_start)
    else $error("count pass did not hand over to rewrite");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.read, cmd.sort_start, cmd.count_issue,
              cmd.fill_start, cmd.fill_step}))
    else $error("overlapping datapath commands");

endmodule

>>> design/range_counting_sort_buffer.sv
// ----------------------------------------------------------------------------
// range_counting_sort_buffer
// letter buffer with load, read and counting sort over an inclusive range
// ----------------------------------------------------------------------------
// load: taken while idle, busy stays low
// read: result strobe in the cycle after the request, busy high for that cycle
// sort: a count pass over the range, one drain state, then a rewrite pass
//   over the range that also steps past the empty bins
// results cannot be stalled; a bad sort range is dropped at once
// reset: synchronous, clears control, histogram and sets length to 1024
// ----------------------------------------------------------------------------
module range_counting_sort_buffer
  import rcsb_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEFAULT,
  parameter int ALPHABET = ALPHABET_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [POS_W-1:0]    position,
  input  logic [LETTER_W-1:0] letter,
  input  logic [POS_W-1:0]    range_start,
  input  logic [POS_W-1:0]    range_end,
  input  logic                ascending,
  input  logic                cfg_we,
  input  logic [LEN_W-1:0]    cfg_wdata,
  output logic                result_strobe,
  output logic [LETTER_W-1:0] read_letter,
  output logic                out_of_range
);

  cmd_t cmd;
  sts_t sts;

  rcsb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy),
    .result_strobe (result_strobe)
  );

  rcsb_datapath #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .position     (position),
    .letter       (letter),
    .range_start  (range_start),
    .range_end    (range_end),
    .ascending    (ascending),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .read_letter  (read_letter),
    .out_of_range (out_of_range)
  );

endmodule
